// File: design/dcws_pkg.sv
// Shared constants and beat layouts for the drive control word sequencer.
package dcws_pkg;

    // Beat widths, padded to whole bytes
    localparam int InDataW  = 104;
    localparam int OutDataW = 72;

    // Field widths
    localparam int StatusW  = 16;
    localparam int ModeW    = 8;
    localparam int SpeedW   = 16;
    localparam int NsW      = 27;
    localparam int BlankW   = NsW + 1;
    localparam int CmdW     = 32;
    localparam int MiscW    = 6;
    localparam int CtrlW    = 9;
    localparam int ModeCmdW = 2;

    // Configuration register indexes
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgAutoReset = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgResetBlank = 1'd1;

    // Drive constants
    localparam logic signed [ModeW-1:0]    VelocityMode = 8'sd2;
    localparam logic [ModeCmdW-1:0]        ModeCmdVelocity = 2'd2;
    localparam logic signed [CmdW-1:0]     SpeedLimitPos = 32'sd32767;
    localparam logic signed [CmdW-1:0]     SpeedLimitNeg = -32'sd32767;
    localparam logic [NsW-1:0]             BlankResetNs = 27'd100000000;

    // Control word bit positions
    localparam int CwSwitchOn   = 0;
    localparam int CwEnableVolt = 1;
    localparam int CwQuickStop  = 2;
    localparam int CwEnableOp   = 3;
    localparam int CwRampLo     = 4;
    localparam int CwFaultReset = 7;
    localparam int CwHalt       = 8;

    // Input beat fields, highest bit first
    typedef struct packed {
        logic                     pad;
        logic signed [CmdW-1:0]   speed_command;
        logic                     halt_req;
        logic                     fault_reset_req;
        logic                     enable_req;
        logic [NsW-1:0]           period_ns;
        logic signed [SpeedW-1:0] speed_feedback;
        logic signed [ModeW-1:0]  mode_display;
        logic [StatusW-1:0]       status_word;
        logic                     link_operational;
    } in_beat_t;

    // Result beat fields, highest bit first
    typedef struct packed {
        logic [2:0]               pad;
        logic [ModeCmdW-1:0]      mode_command;
        logic signed [SpeedW-1:0] speed_setpoint;
        logic [CtrlW-1:0]         control_word;
        logic [SpeedW-1:0]        speed_abs;
        logic signed [SpeedW-1:0] speed_out;
        logic [MiscW-1:0]         status_misc;
        logic                     fault_out;
        logic                     operation_enabled;
        logic                     switched_on;
        logic                     ready_to_switch_on;
    } out_beat_t;

endpackage

// File: design/dcws_skid.sv
// Two-entry output buffer that decouples the result register from downstream stalls.
module dcws_skid (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dcws_pkg::OutDataW-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dcws_pkg::OutDataW-1:0] out_data
);

    logic                          out_valid_reg, out_valid_next;
    logic                          skid_valid_reg, skid_valid_next;
    logic [dcws_pkg::OutDataW-1:0] out_data_reg, out_data_next;
    logic [dcws_pkg::OutDataW-1:0] skid_data_reg, skid_data_next;
    logic                          push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output register when it drains, park a beat in the skid when it stalls
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: design/drive_control_word_sequencer.sv
// Top level of the velocity-mode drive control word sequencer.
// Each input beat is one servo period; it yields exactly one result beat. A beat
// is taken in every clock cycle while the two-entry output buffer has room, and
// its result is registered in the output buffer; the fault, blanking and enable-edge
// state is updated in the same cycle that the beat is accepted, so back-to-back beats see
// the state left by their predecessor. The fault output is forced high while the
// link is down and masked to zero while the auto-reset blanking timer runs; the
// timer counts down by each beat's period_ns. The speed setpoint saturates to
// plus or minus 32767, and the speed outputs repeat the last feedback seen with
// the link up. Configuration writes take effect on the next beat.
module drive_control_word_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [dcws_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [dcws_pkg::NsW-1:0]      cfg_wdata,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: link_operational, status_word[15:0], mode_display[7:0],
    //        speed_feedback[15:0], period_ns[26:0], enable_req,
    //        fault_reset_req, halt_req, speed_command[31:0], zero pad
    input  logic [dcws_pkg::InDataW-1:0]  s_axis_tdata,
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: ready_to_switch_on, switched_on, operation_enabled, fault_out,
    //        status_misc[5:0], speed_out[15:0], speed_abs[15:0],
    //        control_word[8:0], speed_setpoint[15:0], mode_command[1:0], zero pad
    output logic [dcws_pkg::OutDataW-1:0] m_axis_tdata
);

    dcws_pkg::in_beat_t  in_beat;
    dcws_pkg::out_beat_t res;

    logic                               cfg_auto_reg;
    logic [dcws_pkg::NsW-1:0]           cfg_blank_reg;
    logic                               enable_prev_reg, enable_prev_next;
    logic signed [dcws_pkg::BlankW-1:0] blank_reg, blank_next;
    logic signed [dcws_pkg::SpeedW-1:0] speed_hold_reg, speed_hold_next;

    logic accept;
    logic link, rdy, son, opn, fault, drive_fault, blanking, rise, auto_fire;
    logic [dcws_pkg::CtrlW-1:0] cw;

    assign in_beat = dcws_pkg::in_beat_t'(s_axis_tdata);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign link    = in_beat.link_operational;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_auto_reg  <= 1'b1;
            cfg_blank_reg <= dcws_pkg::BlankResetNs;
        end else if (cfg_we) begin
            case (cfg_index)
                dcws_pkg::CfgAutoReset:  cfg_auto_reg  <= cfg_wdata[0];
                dcws_pkg::CfgResetBlank: cfg_blank_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Fault, blanking and control word for the beat being accepted
    always_comb begin
        rdy         = link && in_beat.status_word[0];
        son         = link && in_beat.status_word[1];
        opn         = link && in_beat.status_word[2];
        drive_fault = in_beat.status_word[3] || (in_beat.mode_display != dcws_pkg::VelocityMode);
        blanking    = !blank_reg[dcws_pkg::BlankW-1] && (blank_reg != '0);
        rise        = in_beat.enable_req && !enable_prev_reg;

        blank_next = blank_reg;
        if (!link) begin
            fault = 1'b1;
        end else if (blanking) begin
            fault      = 1'b0;
            blank_next = blank_reg - $signed({1'b0, in_beat.period_ns});
        end else begin
            fault = drive_fault && in_beat.enable_req;
        end

        auto_fire = fault && cfg_auto_reg && rise;
        if (auto_fire) begin
            blank_next = $signed({1'b0, cfg_blank_reg});
        end

        cw = '0;
        cw[dcws_pkg::CwQuickStop] = !in_beat.fault_reset_req;
        if (fault) begin
            cw[dcws_pkg::CwFaultReset] = in_beat.fault_reset_req || auto_fire;
        end else begin
            cw[dcws_pkg::CwEnableVolt] = in_beat.enable_req;
            cw[dcws_pkg::CwSwitchOn]   = in_beat.enable_req && rdy;
            cw[dcws_pkg::CwEnableOp]   = in_beat.enable_req && rdy && son;
            cw[dcws_pkg::CwRampLo +: 3] = {3{opn}};
        end
        cw[dcws_pkg::CwHalt] = in_beat.halt_req;

        enable_prev_next = in_beat.enable_req;
        speed_hold_next  = link ? in_beat.speed_feedback : speed_hold_reg;
    end

    // Assemble the result beat
    always_comb begin
        res                    = '0;
        res.ready_to_switch_on = rdy;
        res.switched_on        = son;
        res.operation_enabled  = opn;
        res.fault_out          = fault;
        if (link) begin
            res.status_misc = {in_beat.status_word[10:9], in_beat.status_word[7:4]};
        end
        res.speed_out = speed_hold_next;
        res.speed_abs = speed_hold_next[dcws_pkg::SpeedW-1]
                      ? dcws_pkg::SpeedW'(-speed_hold_next)
                      : dcws_pkg::SpeedW'(speed_hold_next);
        res.control_word = cw;
        if (in_beat.speed_command > dcws_pkg::SpeedLimitPos) begin
            res.speed_setpoint = dcws_pkg::SpeedW'(dcws_pkg::SpeedLimitPos);
        end else if (in_beat.speed_command < dcws_pkg::SpeedLimitNeg) begin
            res.speed_setpoint = dcws_pkg::SpeedW'(dcws_pkg::SpeedLimitNeg);
        end else begin
            res.speed_setpoint = in_beat.speed_command[dcws_pkg::SpeedW-1:0];
        end
        res.mode_command = dcws_pkg::ModeCmdVelocity;
    end

    // Advance state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_prev_reg <= 1'b0;
            blank_reg       <= '0;
            speed_hold_reg  <= '0;
        end else if (accept) begin
            enable_prev_reg <= enable_prev_next;
            blank_reg       <= blank_next;
            speed_hold_reg  <= speed_hold_next;
        end
    end

    // Result register and skid
    dcws_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (dcws_pkg::OutDataW'(res)),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: test/tb.sv
// Testbench for the drive control word sequencer: random and directed servo periods, scoreboarded.
`timescale 1ns / 1ps

module tb;

    localparam int CycleLimit = 1000000;
    localparam int HoldOffCycles = 300;
    localparam int HoldFirst = 250;
    localparam int HoldEvery = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_we = 1'b0;
    logic [dcws_pkg::CfgIdxW-1:0]  cfg_index = dcws_pkg::CfgAutoReset;
    logic [dcws_pkg::NsW-1:0]      cfg_wdata = '0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    dcws_pkg::in_beat_t  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    dcws_pkg::out_beat_t m_axis_tdata;

    // Servo periods waiting to be offered, and the results they must produce
    dcws_pkg::in_beat_t  pending_q[$];
    dcws_pkg::out_beat_t expected_q[$];

    // Shadow of the block's registers and state
    logic                               auto_rst_on = 1'b1;
    logic [dcws_pkg::NsW-1:0]           blank_ns = dcws_pkg::BlankResetNs;
    logic                               en_last = 1'b0;
    logic                               drv_fault = 1'b0;
    int                                 blank_left = 0;
    logic signed [dcws_pkg::SpeedW-1:0] fb_hold = '0;

    // Flow control
    logic src_gaps_on = 1'b1;
    logic sink_gaps_on = 1'b1;
    logic stim_en = 1'b0;
    int   src_wait = 0;
    int   sink_wait = 0;
    int   sink_hold = 0;
    int   hold_mark = HoldFirst;

    // Bookkeeping
    int                  n_queued = 0;
    int                  n_results = 0;
    int                  n_errors = 0;
    int                  n_cycles = 0;
    int                  n_auto_resets = 0;
    int                  n_blanked = 0;
    int                  n_hold_offs = 0;
    dcws_pkg::out_beat_t want;

    drive_control_word_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advance the shadow state by one servo period and return its result
    function automatic dcws_pkg::out_beat_t servo_period(dcws_pkg::in_beat_t b);
        dcws_pkg::out_beat_t        r;
        logic                       rising;
        logic                       flt;
        logic [dcws_pkg::CtrlW-1:0] cw;
        int                         sp;
        int                         fb_mag;
        r = '0;
        flt = 1'b1;
        if (b.link_operational) begin
            r.ready_to_switch_on = b.status_word[0];
            r.switched_on        = b.status_word[1];
            r.operation_enabled  = b.status_word[2];
            r.status_misc        = {b.status_word[10:9], b.status_word[7:4]};
            drv_fault = b.status_word[3] | (b.mode_display != dcws_pkg::VelocityMode);
            if (blank_left > 0) begin
                blank_left = blank_left - int'(b.period_ns);
                flt = 1'b0;
                n_blanked++;
            end else begin
                flt = drv_fault & b.enable_req;
            end
            fb_hold = b.speed_feedback;
        end
        rising = b.enable_req & ~en_last;
        en_last = b.enable_req;

        // Build the control word
        cw = '0;
        cw[dcws_pkg::CwQuickStop] = ~b.fault_reset_req;
        if (flt) begin
            if (b.fault_reset_req)
                cw[dcws_pkg::CwFaultReset] = 1'b1;
            if (auto_rst_on && rising) begin
                blank_left = int'(blank_ns);
                cw[dcws_pkg::CwFaultReset] = 1'b1;
                n_auto_resets++;
            end
        end else begin
            if (b.enable_req) begin
                cw[dcws_pkg::CwEnableVolt] = 1'b1;
                if (r.ready_to_switch_on) begin
                    cw[dcws_pkg::CwSwitchOn] = 1'b1;
                    if (r.switched_on)
                        cw[dcws_pkg::CwEnableOp] = 1'b1;
                end
            end
            if (r.operation_enabled)
                cw[dcws_pkg::CwRampLo +: 3] = 3'b111;
        end
        cw[dcws_pkg::CwHalt] = b.halt_req;

        // Saturate the setpoint symmetrically
        sp = b.speed_command;
        if (sp > dcws_pkg::SpeedLimitPos)
            sp = dcws_pkg::SpeedLimitPos;
        if (sp < dcws_pkg::SpeedLimitNeg)
            sp = dcws_pkg::SpeedLimitNeg;
        fb_mag = fb_hold;
        if (fb_mag < 0)
            fb_mag = -fb_mag;

        r.fault_out      = flt;
        r.speed_out      = fb_hold;
        r.speed_abs      = fb_mag[dcws_pkg::SpeedW-1:0];
        r.control_word   = cw;
        r.speed_setpoint = sp[dcws_pkg::SpeedW-1:0];
        r.mode_command   = dcws_pkg::ModeCmdVelocity;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic cmp_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            n_errors++;
        end
    endtask

    task automatic send_period(bit link, logic [15:0] sw, logic [7:0] mode, logic [15:0] fb,
                               logic [dcws_pkg::NsW-1:0] per, bit en, bit frst, bit halt,
                               logic [31:0] cmd);
        dcws_pkg::in_beat_t b;
        b = '0;
        b.link_operational = link;
        b.status_word      = sw;
        b.mode_display     = mode;
        b.speed_feedback   = fb;
        b.period_ns        = per;
        b.enable_req       = en;
        b.fault_reset_req  = frst;
        b.halt_req         = halt;
        b.speed_command    = cmd;
        pending_q.push_back(b);
        n_queued++;
    endtask

    // Mostly healthy drive traffic with enable toggling now and then
    task automatic random_periods(int count, int period_max);
        logic [15:0]              sw;
        logic [7:0]               mode;
        logic [15:0]              fb;
        logic [dcws_pkg::NsW-1:0] per;
        logic [31:0]              cmd;
        int                       pick;
        for (int i = 0; i < count; i++) begin
            sw = 16'($urandom_range(0, 16'hffff));
            if ($urandom_range(0, 9) < 7)
                sw[3] = 1'b0;
            if ($urandom_range(0, 99) < 85)
                mode = dcws_pkg::VelocityMode;
            else
                mode = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                fb = 16'h8000;
            else if (pick == 1)
                fb = 16'h7fff;
            else
                fb = 16'($urandom_range(0, 16'hffff));
            pick = $urandom_range(0, 19);
            if (pick < 10)
                per = dcws_pkg::NsW'($urandom_range(0, period_max));
            else if (pick < 12)
                per = dcws_pkg::NsW'($urandom_range(0, 27'h7ffffff));
            else if (pick == 12)
                per = '0;
            else
                per = dcws_pkg::NsW'($urandom_range(0, 2000));
            if ($urandom_range(0, 4) == 0)
                stim_en = ~stim_en;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                cmd = $urandom_range(0, 80000) - 40000;
            end else if (pick < 8) begin
                cmd = $urandom;
            end else begin
                case ($urandom_range(0, 5))
                    0: cmd = 32'd32767;
                    1: cmd = 32'd32768;
                    2: cmd = -32'sd32767;
                    3: cmd = -32'sd32768;
                    4: cmd = 32'h7fffffff;
                    default: cmd = 32'h80000000;
                endcase
            end
            send_period($urandom_range(0, 9) != 0, sw, mode, fb, per, stim_en,
                        $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)), cmd);
        end
    endtask

    task automatic write_reg(logic [dcws_pkg::CfgIdxW-1:0] idx, logic [dcws_pkg::NsW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == dcws_pkg::CfgAutoReset)
            auto_rst_on = val[0];
        else
            blank_ns = val;
    endtask

    task automatic wait_idle();
        do
            @(posedge aclk);
        while (n_results != n_queued);
    endtask

    // Driver: offer pending beats, with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(servo_period(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_axis_tdata  <= pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (src_gaps_on)
                        src_wait = idle_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold-off timer: block the result side for a long stretch now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (n_results >= hold_mark) begin
            sink_hold <= HoldOffCycles;
            hold_mark = hold_mark + HoldEvery;
            n_hold_offs++;
        end
    end

    // Monitor: check each result beat and stall the result side now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat arrived with nothing expected");
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    cmp_field("ready_to_switch_on", want.ready_to_switch_on,
                              m_axis_tdata.ready_to_switch_on);
                    cmp_field("switched_on", want.switched_on, m_axis_tdata.switched_on);
                    cmp_field("operation_enabled", want.operation_enabled,
                              m_axis_tdata.operation_enabled);
                    cmp_field("fault_out", want.fault_out, m_axis_tdata.fault_out);
                    cmp_field("status_misc", want.status_misc, m_axis_tdata.status_misc);
                    cmp_field("speed_out", want.speed_out, m_axis_tdata.speed_out);
                    cmp_field("speed_abs", want.speed_abs, m_axis_tdata.speed_abs);
                    cmp_field("control_word", want.control_word, m_axis_tdata.control_word);
                    cmp_field("speed_setpoint", want.speed_setpoint,
                              m_axis_tdata.speed_setpoint);
                    cmp_field("mode_command", want.mode_command, m_axis_tdata.mode_command);
                end
                n_results++;
            end
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_gaps_on)
                    sink_wait = idle_len();
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: link down, enable chain, saturation, fault, auto reset and blanking
        send_period(1'b0, 16'h0000, 8'd2, 16'h0000, 27'd0, 1'b0, 1'b0, 1'b0, 32'd0);
        send_period(1'b1, 16'h0000, 8'd2, 16'h7fff, 27'd1000, 1'b0, 1'b0, 1'b0, 32'd0);
        send_period(1'b1, 16'h0007, 8'd2, 16'h8000, 27'd1000, 1'b1, 1'b0, 1'b0, 32'd32767);
        send_period(1'b1, 16'hfff7, 8'd2, 16'hffff, 27'd1000, 1'b1, 1'b0, 1'b1,
                    -32'sd32767);
        send_period(1'b1, 16'h0003, 8'd2, 16'h0001, 27'd1000, 1'b1, 1'b0, 1'b0, 32'd32768);
        send_period(1'b1, 16'h0007, 8'd2, 16'h0002, 27'd1000, 1'b1, 1'b1, 1'b1,
                    32'h80000000);
        send_period(1'b1, 16'h0001, 8'd2, 16'h0003, 27'd1000, 1'b1, 1'b0, 1'b0,
                    32'h7fffffff);
        send_period(1'b1, 16'h0001, 8'd2, 16'h0004, 27'd1000, 1'b1, 1'b0, 1'b0,
                    -32'sd32768);
        send_period(1'b1, 16'h0008, 8'd2, 16'h0005, 27'd1000, 1'b1, 1'b1, 1'b0, 32'd100);
        send_period(1'b1, 16'h0008, 8'd2, 16'h0006, 27'd1000, 1'b0, 1'b0, 1'b0, 32'd100);
        send_period(1'b1, 16'h0008, 8'd2, 16'h0007, 27'd1000, 1'b1, 1'b0, 1'b0, 32'd100);
        send_period(1'b1, 16'h0008, 8'd2, 16'h0008, 27'd60000000, 1'b1, 1'b0, 1'b0, 32'd5);
        send_period(1'b1, 16'h0000, 8'h80, 16'h0009, 27'd40000000, 1'b1, 1'b0, 1'b0, 32'd5);
        send_period(1'b1, 16'h0000, 8'h7f, 16'h000a, 27'd1000, 1'b1, 1'b0, 1'b1, 32'd5);
        send_period(1'b0, 16'hffff, 8'd2, 16'd1234, 27'd1000, 1'b0, 1'b0, 1'b0, 32'd5);
        send_period(1'b0, 16'hffff, 8'd2, 16'd4321, 27'd1000, 1'b1, 1'b0, 1'b0, 32'd5);
        send_period(1'b1, 16'h0000, 8'd2, 16'h8000, 27'h7ffffff, 1'b1, 1'b0, 1'b0, 32'd5);
        send_period(1'b1, 16'hffff, 8'd2, 16'h0010, 27'd1000, 1'b1, 1'b1, 1'b0, 32'd5);
        wait_idle();

        // Auto reset off, no blanking
        write_reg(dcws_pkg::CfgAutoReset, 27'd0);
        write_reg(dcws_pkg::CfgResetBlank, 27'd0);
        random_periods(150, 2000);
        wait_idle();

        // Longest blanking, no random gaps on the result side
        write_reg(dcws_pkg::CfgAutoReset, 27'd1);
        write_reg(dcws_pkg::CfgResetBlank, 27'h7ffffff);
        sink_gaps_on = 1'b0;
        random_periods(150, 40000000);
        wait_idle();

        // Zero blanking, no random gaps on either side
        write_reg(dcws_pkg::CfgResetBlank, 27'd0);
        src_gaps_on = 1'b0;
        random_periods(150, 1000);
        wait_idle();

        // Random blanking time, gaps on both sides, with a pause in the middle
        write_reg(dcws_pkg::CfgResetBlank, dcws_pkg::NsW'($urandom_range(1, 200000)));
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        random_periods(220, 50000);
        wait_idle();
        random_periods(230, 50000);
        wait_idle();
        repeat (4) @(posedge aclk);

        $display("Covered %0d servo periods in five register settings: %0d auto resets,",
                 n_results, n_auto_resets);
        $display("%0d blanked periods, %0d long result stalls, %0d mismatches",
                 n_blanked, n_hold_offs, n_errors);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/dcws_pkg.sv
design/dcws_skid.sv
design/drive_control_word_sequencer.sv
test/tb.sv
